// ===== rtl/tmssd_pkg.sv =====
package tmssd_pkg;

  localparam int unsigned MaxTplW  = 32;
  localparam int unsigned MaxTplH  = 32;
  localparam int unsigned MaxImgH  = 1024;
  localparam int unsigned MaxImgW  = 1024;
  localparam int unsigned ColBits  = $clog2(MaxTplW);
  localparam int unsigned RowBits  = $clog2(MaxImgH);
  localparam int unsigned TplDepth = MaxTplW * MaxTplH;
  localparam int unsigned TplAw    = $clog2(TplDepth);
  localparam int unsigned BufDepth = MaxTplW * MaxImgH;
  localparam int unsigned BufAw    = $clog2(BufDepth);

  localparam logic [2:0] CFG_MODE   = 3'd0;
  localparam logic [2:0] CFG_IMG_H  = 3'd1;
  localparam logic [2:0] CFG_IMG_W  = 3'd2;
  localparam logic [2:0] CFG_TPL_H  = 3'd3;
  localparam logic [2:0] CFG_TPL_W  = 3'd4;

  typedef struct packed {
    logic        mode;
    logic [10:0] ih;
    logic [10:0] iw;
    logic [5:0]  th;
    logic [5:0]  tw;
    logic [10:0] n;
  } cfg_t;

  typedef struct packed {
    logic [9:0] wc;
    logic [9:0] wr;
    logic       last;
  } job_t;

  function automatic logic [10:0] clamp11(logic [10:0] v, logic [10:0] lo, logic [10:0] hi);
    logic [10:0] r;
    r = v;
    if (v < lo) r = lo;
    else if (v > hi) r = hi;
    return r;
  endfunction

  function automatic logic [5:0] clamp6(logic [5:0] v, logic [5:0] lo, logic [5:0] hi);
    logic [5:0] r;
    r = v;
    if (v < lo) r = lo;
    else if (v > hi) r = hi;
    return r;
  endfunction

endpackage

// ===== rtl/tmssd_ram.sv =====
module tmssd_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

// ===== rtl/tmssd_front.sv =====
module tmssd_front (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          push_i,
  output logic                          full_o,
  input  logic                          op_i,
  input  logic [7:0]                    sample_i,
  input  logic                          cfg_valid_i,
  input  logic [2:0]                    cfg_index_i,
  input  logic [10:0]                   cfg_data_i,
  input  logic                          back_busy_i,
  input  logic                          q_full_i,
  input  logic                          q_empty_i,
  output tmssd_pkg::cfg_t               cfg_o,
  output logic                          tpl_we_o,
  output logic [tmssd_pkg::TplAw-1:0]   tpl_waddr_o,
  output logic                          buf_we_o,
  output logic [tmssd_pkg::BufAw-1:0]   buf_waddr_o,
  output logic [7:0]                    wdata_o,
  output logic                          job_push_o,
  output tmssd_pkg::job_t               job_o
);
  import tmssd_pkg::*;

  logic        mode_q;
  logic [10:0] ih_q, iw_q;
  logic [5:0]  th_q, tw_q;
  logic [10:0] tlc_q, tlc_d, tlc_base;
  logic [9:0]  col_q, row_q, col_d, row_d, col_e, row_e, last_col_q;
  logic [10:0] ih, iw, col1, row1, wc, wr;
  logic [5:0]  th, tw;
  logic        tpl_done, oob, win, busy, img_ok, acc;

  assign ih = clamp11(ih_q, 11'd1, 11'(MaxImgH));
  assign iw = clamp11(iw_q, 11'd1, 11'(MaxImgW));
  assign th = clamp6(th_q, 6'd2, 6'(MaxTplH));
  assign tw = clamp6(tw_q, 6'd1, 6'(MaxTplW));

  always_comb begin
    cfg_o.mode = mode_q;
    cfg_o.ih   = ih;
    cfg_o.iw   = iw;
    cfg_o.th   = th;
    cfg_o.tw   = tw;
    cfg_o.n    = 11'(th) * 11'(tw);
  end

  assign tpl_done = tlc_q >= cfg_o.n;
  assign oob      = ({1'b0, row_q} >= ih) || ({1'b0, col_q} >= iw);
  assign col_e    = oob ? '0 : col_q;
  assign row_e    = oob ? '0 : row_q;
  assign col1     = {1'b0, col_e} + 11'd1;
  assign row1     = {1'b0, row_e} + 11'd1;
  assign win      = (col1 >= {5'b0, tw}) && (row1 >= {5'b0, th});
  assign wc       = col1 - {5'b0, tw};
  assign wr       = row1 - {5'b0, th};
  assign busy     = back_busy_i || !q_empty_i;
  // pending windows all end in the current column at earlier rows
  assign img_ok   = (!busy || (col_e == last_col_q && row_e != '0)) && !(win && q_full_i);
  assign full_o   = op_i ? (tpl_done && !img_ok) : busy;
  assign acc      = push_i && !full_o;

  assign tlc_base    = tpl_done ? '0 : tlc_q;
  assign tpl_we_o    = acc && !op_i;
  assign tpl_waddr_o = tlc_base[TplAw-1:0];
  assign buf_we_o    = acc && op_i && tpl_done;
  assign buf_waddr_o = {col_e[ColBits-1:0], row_e[RowBits-1:0]};
  assign wdata_o     = sample_i;
  assign job_push_o  = buf_we_o && win;
  assign job_o.wc    = wc[9:0];
  assign job_o.wr    = wr[9:0];
  assign job_o.last  = (wc == iw - {5'b0, tw}) && (wr == ih - {5'b0, th});

  always_comb begin
    tlc_d = tlc_q;
    col_d = col_q;
    row_d = row_q;
    if (tpl_we_o) begin
      tlc_d = tlc_base + 11'd1;
      col_d = '0;
      row_d = '0;
    end else if (buf_we_o) begin
      if (row1 >= ih) begin
        row_d = '0;
        col_d = (col1 >= iw) ? '0 : col1[9:0];
      end else begin
        row_d = row1[9:0];
        col_d = col_e;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q     <= 1'b0;
      ih_q       <= 11'd1024;
      iw_q       <= 11'd1024;
      th_q       <= 6'd8;
      tw_q       <= 6'd8;
      tlc_q      <= '0;
      col_q      <= '0;
      row_q      <= '0;
      last_col_q <= '0;
    end else begin
      if (cfg_valid_i) begin
        case (cfg_index_i)
          CFG_MODE:  mode_q <= cfg_data_i[0];
          CFG_IMG_H: ih_q   <= cfg_data_i;
          CFG_IMG_W: iw_q   <= cfg_data_i;
          CFG_TPL_H: th_q   <= cfg_data_i[5:0];
          CFG_TPL_W: tw_q   <= cfg_data_i[5:0];
          default: ;
        endcase
      end
      tlc_q <= tlc_d;
      col_q <= col_d;
      row_q <= row_d;
      if (job_push_o) begin
        last_col_q <= col_e;
      end
    end
  end

endmodule

// ===== rtl/tmssd_jobq.sv =====
module tmssd_jobq (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  tmssd_pkg::job_t data_i,
  output logic            full_o,
  input  logic            pop_i,
  output logic            empty_o,
  output tmssd_pkg::job_t data_o
);
  import tmssd_pkg::*;

  job_t       ent_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  logic       do_push, do_pop;

  assign full_o  = cnt_q == 2'd2;
  assign empty_o = cnt_q == 2'd0;
  assign data_o  = ent_q[rp_q];
  assign do_push = push_i && !full_o;
  assign do_pop  = pop_i && !empty_o;

  always_ff @(posedge clk_i) begin
    if (do_push) begin
      ent_q[wp_q] <= data_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= '0;
    end else begin
      if (do_push) wp_q <= !wp_q;
      if (do_pop) rp_q <= !rp_q;
      cnt_q <= cnt_q + {1'b0, do_push} - {1'b0, do_pop};
    end
  end

endmodule

// ===== rtl/tmssd_back.sv =====
module tmssd_back (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  tmssd_pkg::cfg_t              cfg_i,
  input  logic                         job_empty_i,
  input  tmssd_pkg::job_t              job_i,
  output logic                         job_pop_o,
  output logic                         busy_o,
  output logic [tmssd_pkg::TplAw-1:0]  tpl_raddr_o,
  output logic [tmssd_pkg::BufAw-1:0]  buf_raddr_o,
  input  logic [7:0]                   tpl_rdata_i,
  input  logic [7:0]                   buf_rdata_i,
  input  logic                         pop_i,
  output logic                         empty_o,
  output logic [31:0]                  score_o,
  output logic [9:0]                   window_col_o,
  output logic [9:0]                   window_row_o,
  output logic                         degenerate_o,
  output logic                         last_window_o
);
  import tmssd_pkg::*;

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_WALK  = 4'd1;
  localparam logic [3:0] ST_DRAIN = 4'd2;
  localparam logic [3:0] ST_VA0   = 4'd3;
  localparam logic [3:0] ST_VA1   = 4'd4;
  localparam logic [3:0] ST_VB0   = 4'd5;
  localparam logic [3:0] ST_VB1   = 4'd6;
  localparam logic [3:0] ST_C0    = 4'd7;
  localparam logic [3:0] ST_C1    = 4'd8;
  localparam logic [3:0] ST_SQRT  = 4'd9;
  localparam logic [3:0] ST_DEN   = 4'd10;
  localparam logic [3:0] ST_DIV   = 4'd11;
  localparam logic [3:0] ST_F     = 4'd12;
  localparam logic [3:0] ST_SCORE = 4'd13;
  localparam logic [3:0] ST_OUT   = 4'd14;

  logic [3:0]  state_q;
  job_t        job_q;
  logic [5:0]  mx_q, my_q;
  logic [9:0]  rd_row_q;
  logic [4:0]  rd_col_q;
  logic [9:0]  tidx_q;
  logic        d1_q;
  logic [25:0] ssd_q, saa_q, sbb_q, sab_q;
  logic [17:0] sa_q, sb_q;
  logic [36:0] prod_q, va_q, vb_q;
  logic        cneg_q, deg_q;
  logic [37:0] mag_q;
  logic [63:0] sq_v_q, sq_res_q, sq_bit_q;
  logic [4:0]  sq_cnt_q;
  logic        sq_sel_q;
  logic [30:0] ra_q;
  logic [61:0] den_q, dvd_q;
  logic [62:0] rem_q;
  logic [31:0] q_q;
  logic        sat_q;
  logic [6:0]  dcnt_q;
  logic [31:0] f_q, sc_q;
  logic        out_v_q;
  logic [31:0] out_score_q;
  logic [9:0]  out_wc_q, out_wr_q;
  logic        out_deg_q, out_last_q;

  logic [7:0]  a, b, d;
  logic [15:0] dd, aa, bb, ab;
  logic [35:0] sq36;
  logic [36:0] p37;
  logic [63:0] sq_sum, sq_res_n;
  logic        sq_ge;
  logic [62:0] rem_sh;
  logic        div_ge;
  logic [31:0] qc;
  logic [43:0] sprod;
  logic [11:0] nm1x2;

  assign a     = buf_rdata_i;
  assign b     = tpl_rdata_i;
  assign d     = (a > b) ? a - b : b - a;
  assign dd    = d * d;
  assign aa    = a * a;
  assign bb    = b * b;
  assign ab    = a * b;
  assign nm1x2 = {cfg_i.n - 11'd1, 1'b0};

  assign busy_o      = state_q != ST_IDLE;
  assign job_pop_o   = (state_q == ST_IDLE) && !job_empty_i;
  assign tpl_raddr_o = tidx_q;
  assign buf_raddr_o = {rd_col_q, rd_row_q};

  always_comb begin
    case (state_q)
      ST_VA1:  sq36 = sa_q * sa_q;
      ST_VB1:  sq36 = sb_q * sb_q;
      default: sq36 = sa_q * sb_q;
    endcase
  end

  always_comb begin
    case (state_q)
      ST_VA0:  p37 = cfg_i.n * saa_q;
      ST_VB0:  p37 = cfg_i.n * sbb_q;
      default: p37 = cfg_i.n * sab_q;
    endcase
  end

  assign sq_sum   = sq_res_q + sq_bit_q;
  assign sq_ge    = sq_v_q >= sq_sum;
  assign sq_res_n = sq_ge ? ((sq_res_q >> 1) + sq_bit_q) : (sq_res_q >> 1);

  assign rem_sh = {rem_q[61:0], dvd_q[61]};
  assign div_ge = rem_sh >= {1'b0, den_q};
  assign qc     = (sat_q || q_q > 32'h4000_0000) ? 32'h4000_0000 : q_q;
  assign sprod  = nm1x2 * f_q;

  assign empty_o       = !out_v_q;
  assign score_o       = out_score_q;
  assign window_col_o  = out_wc_q;
  assign window_row_o  = out_wr_q;
  assign degenerate_o  = out_deg_q;
  assign last_window_o = out_last_q;

  always_ff @(posedge clk_i) begin
    if (job_pop_o) begin
      job_q    <= job_i;
      mx_q     <= '0;
      my_q     <= '0;
      rd_row_q <= job_i.wr;
      rd_col_q <= job_i.wc[4:0];
      tidx_q   <= '0;
      ssd_q    <= '0;
      saa_q    <= '0;
      sbb_q    <= '0;
      sab_q    <= '0;
      sa_q     <= '0;
      sb_q     <= '0;
      deg_q    <= 1'b0;
      sc_q     <= '0;
    end else begin
      if (d1_q) begin
        ssd_q <= ssd_q + 26'(dd);
        saa_q <= saa_q + 26'(aa);
        sbb_q <= sbb_q + 26'(bb);
        sab_q <= sab_q + 26'(ab);
        sa_q  <= sa_q + 18'(a);
        sb_q  <= sb_q + 18'(b);
      end
      case (state_q)
        ST_WALK: begin
          tidx_q <= tidx_q + 10'd1;
          if (my_q == cfg_i.th - 6'd1) begin
            my_q     <= '0;
            rd_row_q <= job_q.wr;
            rd_col_q <= rd_col_q + 5'd1;
            mx_q     <= mx_q + 6'd1;
          end else begin
            my_q     <= my_q + 6'd1;
            rd_row_q <= rd_row_q + 10'd1;
          end
        end
        ST_VA0, ST_VB0, ST_C0: prod_q <= p37;
        ST_VA1: va_q <= prod_q - {1'b0, sq36};
        ST_VB1: vb_q <= prod_q - {1'b0, sq36};
        ST_C1: begin
          cneg_q <= prod_q < {1'b0, sq36};
          mag_q  <= (prod_q < {1'b0, sq36}) ? 38'({1'b0, sq36} - prod_q)
                                            : 38'(prod_q - {1'b0, sq36});
          if (va_q == '0 || vb_q == '0) begin
            deg_q <= 1'b1;
          end
          sq_v_q   <= {3'b0, va_q, 24'b0};
          sq_res_q <= '0;
          sq_bit_q <= 64'h4000_0000_0000_0000;
          sq_cnt_q <= '0;
          sq_sel_q <= 1'b0;
        end
        ST_SQRT: begin
          sq_cnt_q <= sq_cnt_q + 5'd1;
          if (sq_cnt_q == 5'd31) begin
            sq_v_q   <= {3'b0, vb_q, 24'b0};
            sq_res_q <= '0;
            sq_bit_q <= 64'h4000_0000_0000_0000;
            sq_sel_q <= 1'b1;
            if (!sq_sel_q) ra_q <= sq_res_n[30:0];
            else den_q <= {31'b0, ra_q} * {31'b0, sq_res_n[30:0]};
          end else begin
            if (sq_ge) sq_v_q <= sq_v_q - sq_sum;
            sq_res_q <= sq_res_n;
            sq_bit_q <= sq_bit_q >> 2;
          end
        end
        ST_DEN: begin
          rem_q  <= '0;
          dvd_q  <= {mag_q, 24'b0};
          q_q    <= '0;
          sat_q  <= 1'b0;
          dcnt_q <= '0;
        end
        ST_DIV: begin
          dcnt_q <= dcnt_q + 7'd1;
          dvd_q  <= {dvd_q[60:0], 1'b0};
          rem_q  <= div_ge ? rem_sh - {1'b0, den_q} : rem_sh;
          q_q    <= {q_q[30:0], div_ge};
          sat_q  <= sat_q | q_q[31];
        end
        ST_F: f_q <= cneg_q ? 32'h4000_0000 + qc : 32'h4000_0000 - qc;
        ST_SCORE: sc_q <= {2'b0, sprod[43:14]};
        default: ;
      endcase
    end
    if (state_q == ST_OUT && !out_v_q) begin
      out_score_q <= cfg_i.mode ? sc_q : {6'b0, ssd_q};
      out_wc_q    <= job_q.wc;
      out_wr_q    <= job_q.wr;
      out_deg_q   <= cfg_i.mode & deg_q;
      out_last_q  <= job_q.last;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      d1_q    <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      d1_q <= state_q == ST_WALK;
      if (pop_i && out_v_q) out_v_q <= 1'b0;
      case (state_q)
        ST_IDLE:  if (job_pop_o) state_q <= ST_WALK;
        ST_WALK: begin
          if (my_q == cfg_i.th - 6'd1 && mx_q == cfg_i.tw - 6'd1) state_q <= ST_DRAIN;
        end
        ST_DRAIN: state_q <= cfg_i.mode ? ST_VA0 : ST_OUT;
        ST_VA0:   state_q <= ST_VA1;
        ST_VA1:   state_q <= ST_VB0;
        ST_VB0:   state_q <= ST_VB1;
        ST_VB1:   state_q <= ST_C0;
        ST_C0:    state_q <= ST_C1;
        ST_C1:    state_q <= (va_q == '0 || vb_q == '0) ? ST_OUT : ST_SQRT;
        ST_SQRT:  if (sq_cnt_q == 5'd31 && sq_sel_q) state_q <= ST_DEN;
        ST_DEN:   state_q <= ST_DIV;
        ST_DIV:   if (dcnt_q == 7'd91) state_q <= ST_F;
        ST_F:     state_q <= ST_SCORE;
        ST_SCORE: state_q <= ST_OUT;
        ST_OUT: begin
          if (!out_v_q) begin
            out_v_q <= 1'b1;
            state_q <= ST_IDLE;
          end
        end
        default:  state_q <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/template_match_ssd_nssd.sv =====
// Results: mode 0 gives the SSD once the template walk and its drain are done; mode 1 then adds
// variance terms, two 32-step square roots and a 92-step divider; a degenerate window skips the last two.
// Windows are walked with one RAM read per cycle. Image samples are taken every cycle unless a
// window is pending and they open a new column, or they complete one while the job queue is full.
// Async active-low reset clears control; RAM contents stay undefined.
module template_match_ssd_nssd (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push,
  output logic        full,
  input  logic        op_i,
  input  logic [7:0]  sample_i,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] score_o,
  output logic [9:0]  window_col_o,
  output logic [9:0]  window_row_o,
  output logic        degenerate_o,
  output logic        last_window_o,
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic [2:0]  cfg_index_i,
  input  logic [10:0] cfg_data_i
);
  import tmssd_pkg::*;

  cfg_t              cfg;
  job_t              job_in, job_out;
  logic              job_push, job_pop, q_full, q_empty, back_busy;
  logic              tpl_we, buf_we;
  logic [TplAw-1:0]  tpl_waddr, tpl_raddr;
  logic [BufAw-1:0]  buf_waddr, buf_raddr;
  logic [7:0]        wdata, tpl_rdata, buf_rdata;

  assign cfg_ready_o = 1'b1;

  tmssd_front u_front (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .push_i      (push),
    .full_o      (full),
    .op_i        (op_i),
    .sample_i    (sample_i),
    .cfg_valid_i (cfg_valid_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .back_busy_i (back_busy),
    .q_full_i    (q_full),
    .q_empty_i   (q_empty),
    .cfg_o       (cfg),
    .tpl_we_o    (tpl_we),
    .tpl_waddr_o (tpl_waddr),
    .buf_we_o    (buf_we),
    .buf_waddr_o (buf_waddr),
    .wdata_o     (wdata),
    .job_push_o  (job_push),
    .job_o       (job_in)
  );

  tmssd_jobq u_jobq (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (job_push),
    .data_i  (job_in),
    .full_o  (q_full),
    .pop_i   (job_pop),
    .empty_o (q_empty),
    .data_o  (job_out)
  );

  tmssd_ram #(.Width(8), .Depth(TplDepth)) u_tpl_ram (
    .clk_i   (clk_i),
    .we_i    (tpl_we),
    .waddr_i (tpl_waddr),
    .wdata_i (wdata),
    .raddr_i (tpl_raddr),
    .rdata_o (tpl_rdata)
  );

  tmssd_ram #(.Width(8), .Depth(BufDepth)) u_buf_ram (
    .clk_i   (clk_i),
    .we_i    (buf_we),
    .waddr_i (buf_waddr),
    .wdata_i (wdata),
    .raddr_i (buf_raddr),
    .rdata_o (buf_rdata)
  );

  tmssd_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_i         (cfg),
    .job_empty_i   (q_empty),
    .job_i         (job_out),
    .job_pop_o     (job_pop),
    .busy_o        (back_busy),
    .tpl_raddr_o   (tpl_raddr),
    .buf_raddr_o   (buf_raddr),
    .tpl_rdata_i   (tpl_rdata),
    .buf_rdata_i   (buf_rdata),
    .pop_i         (pop),
    .empty_o       (empty),
    .score_o       (score_o),
    .window_col_o  (window_col_o),
    .window_row_o  (window_row_o),
    .degenerate_o  (degenerate_o),
    .last_window_o (last_window_o)
  );

endmodule

// ===== verif/template_match_ssd_nssd_tb.sv =====
module template_match_ssd_nssd_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import tmssd_pkg::*;

  class ssd_scoreboard;
    typedef struct {
      bit [31:0] score;
      bit [9:0]  wc;
      bit [9:0]  wr;
      bit        deg;
      bit        last;
    } window_t;

    bit [7:0]    tpl_mem[TplDepth];
    bit [7:0]    col_mem[BufDepth];
    int unsigned loaded, cpos, rpos;
    bit          mode;
    bit [10:0]   img_h, img_w;
    bit [5:0]    tpl_h, tpl_w;
    window_t     want[$];
    int          errors;

    function new();
      img_h = 1024;
      img_w = 1024;
      tpl_h = 8;
      tpl_w = 8;
    endfunction

    function int unsigned lim(int unsigned v, int unsigned lo, int unsigned hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function int unsigned eff_h();  return lim(img_h, 1, MaxImgH); endfunction
    function int unsigned eff_w();  return lim(img_w, 1, MaxImgW); endfunction
    function int unsigned eff_th(); return lim(tpl_h, 2, MaxTplH); endfunction
    function int unsigned eff_tw(); return lim(tpl_w, 1, MaxTplW); endfunction
    function int unsigned tpl_size(); return eff_th() * eff_tw(); endfunction

    function void set_reg(logic [2:0] idx, logic [10:0] v);
      case (idx)
        CFG_MODE:  mode  = v[0];
        CFG_IMG_H: img_h = v;
        CFG_IMG_W: img_w = v;
        CFG_TPL_H: tpl_h = v[5:0];
        CFG_TPL_W: tpl_w = v[5:0];
        default: ;
      endcase
    endfunction

    function longint unsigned root64(longint unsigned v);
      longint unsigned res, bt;
      res = 0;
      bt = 64'd1 << 62;
      while (bt > v) bt >>= 2;
      while (bt != 0) begin
        if (v >= res + bt) begin
          v -= res + bt;
          res = (res >> 1) + bt;
        end else begin
          res >>= 1;
        end
        bt >>= 2;
      end
      return res;
    endfunction

    function void note_input(bit op, bit [7:0] s);
      int unsigned ih, iw, th, tw, n, col, row, wc, wr;
      longint unsigned a, b, d, ssd, sa, saa, sb, sbb, sab, va, vb, mag, den, num, q, r, f, k;
      longint unsigned sc;
      longint c;
      window_t w;
      ih = eff_h(); iw = eff_w(); th = eff_th(); tw = eff_tw();
      n = th * tw;
      if (op == 1'b0) begin
        if (loaded >= n) loaded = 0;
        tpl_mem[loaded % TplDepth] = s;
        loaded++;
        cpos = 0;
        rpos = 0;
        return;
      end
      if (loaded < n) return;
      col = cpos;
      row = rpos;
      if (row >= ih || col >= iw) begin
        col = 0;
        row = 0;
      end
      col_mem[(col % MaxTplW) * MaxImgH + row] = s;
      if (col + 1 >= tw && row + 1 >= th) begin
        wc = col + 1 - tw;
        wr = row + 1 - th;
        ssd = 0; sa = 0; saa = 0; sb = 0; sbb = 0; sab = 0;
        w.deg = 1'b0;
        for (int x = 0; x < tw; x++) begin
          for (int y = 0; y < th; y++) begin
            a = col_mem[((wc + x) % MaxTplW) * MaxImgH + wr + y];
            b = tpl_mem[(x * th + y) % TplDepth];
            d = a > b ? a - b : b - a;
            ssd += d * d;
            sa += a; saa += a * a;
            sb += b; sbb += b * b;
            sab += a * b;
          end
        end
        sc = 0;
        if (!mode) begin
          sc = ssd;
        end else begin
          va = n * saa - sa * sa;
          vb = n * sbb - sb * sb;
          if (va == 0 || vb == 0) begin
            w.deg = 1'b1;
          end else begin
            c = longint'(n * sab) - longint'(sa * sb);
            mag = c < 0 ? longint'(-c) : c;
            den = root64(va << 24) * root64(vb << 24);
            num = mag << 24;
            q = num / den;
            r = num % den;
            k = longint'(2 * (n - 1)) << 16;
            for (int i = 0; i < 30; i++) begin
              r <<= 1;
              q <<= 1;
              if (r >= den) begin
                r -= den;
                q |= 1;
              end
            end
            if (q > (64'd1 << 30)) q = 64'd1 << 30;
            f = c >= 0 ? (64'd1 << 30) - q : (64'd1 << 30) + q;
            sc = (k * f) >> 30;
          end
        end
        if (sc > 64'hFFFF_FFFF) sc = 64'hFFFF_FFFF;
        w.score = sc[31:0];
        w.wc = wc[9:0];
        w.wr = wr[9:0];
        w.last = (wc == iw - tw && wr == ih - th);
        want.push_back(w);
      end
      row++;
      if (row >= ih) begin
        row = 0;
        col++;
        if (col >= iw) col = 0;
      end
      cpos = col;
      rpos = row;
    endfunction

    function void check_window(bit [31:0] score, bit [9:0] wc, bit [9:0] wr, bit deg, bit last);
      window_t w;
      if (want.size() == 0) begin
        $error("window with no request pending");
        errors++;
        return;
      end
      w = want.pop_front();
      if (score !== w.score) begin
        $error("score exp %0d got %0d", w.score, score); errors++;
      end
      if (wc !== w.wc) begin
        $error("window_col exp %0d got %0d", w.wc, wc); errors++;
      end
      if (wr !== w.wr) begin
        $error("window_row exp %0d got %0d", w.wr, wr); errors++;
      end
      if (deg !== w.deg) begin
        $error("degenerate exp %0d got %0d", w.deg, deg); errors++;
      end
      if (last !== w.last) begin
        $error("last_window exp %0d got %0d", w.last, last); errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        full;
  logic        op_i = 1'b0;
  logic [7:0]  sample_i = '0;
  logic        empty;
  logic        pop = 1'b0;
  logic [31:0] score_o;
  logic [9:0]  window_col_o, window_row_o;
  logic        degenerate_o, last_window_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic [2:0]  cfg_index_i = '0;
  logic [10:0] cfg_data_i = '0;

  ssd_scoreboard sb = new();
  bit steady;
  bit hold_rx;

  template_match_ssd_nssd DUT (.*);

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  initial begin
    #20ms;
    $display("Regression FAIL");
    $finish;
  end

  function automatic int idle_len();
    int unsigned p;
    p = $urandom_range(0, 99);
    if (p < 55) return 0;
    if (p < 92) return $urandom_range(1, 3);
    return $urandom_range(10, 60);
  endfunction

  // result side
  initial begin
    int stall_left;
    stall_left = 0;
    wait (rst_ni);
    forever begin
      @(posedge clk_i);
      if (pop && !empty)
        sb.check_window(score_o, window_col_o, window_row_o, degenerate_o, last_window_o);
      if (hold_rx) begin
        hold_rx = 1'b0;
        stall_left = 3000;
      end
      if (stall_left > 0) begin
        pop <= 1'b0;
        stall_left--;
      end else begin
        pop <= 1'b1;
        if (!steady) stall_left = idle_len();
      end
    end
  end

  task automatic send_item(bit op, bit [7:0] s);
    int g;
    push <= 1'b1;
    op_i <= op;
    sample_i <= s;
    do @(posedge clk_i); while (full);
    sb.note_input(op, s);
    g = steady ? 0 : idle_len();
    if (g > 0) begin
      push <= 1'b0;
      repeat (g) @(posedge clk_i);
    end
  endtask

  task automatic cfg_write(logic [2:0] idx, logic [10:0] v);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= v;
    do @(posedge clk_i); while (!cfg_ready_o);
    sb.set_reg(idx, v);
    cfg_valid_i <= 1'b0;
  endtask

  task automatic settle();
    while (sb.want.size() != 0) @(posedge clk_i);
    repeat (1300) @(posedge clk_i);
  endtask

  function automatic bit [7:0] pick(int style);
    case (style)
      1: return $urandom_range(0, 1) ? 8'hFF : 8'h00;
      2: return 8'd77;
      3: return 8'd100 + 8'($urandom_range(0, 7));
      default: return 8'($urandom);
    endcase
  endfunction

  task automatic run_phase(bit m, int h, int w, int th, int tw, int imgs, bit reload,
                           int style);
    settle();
    cfg_write(CFG_MODE, 11'(m));
    cfg_write(CFG_IMG_H, 11'(h));
    cfg_write(CFG_IMG_W, 11'(w));
    cfg_write(CFG_TPL_H, 11'(th));
    cfg_write(CFG_TPL_W, 11'(tw));
    if (reload)
      for (int i = 0; i < sb.tpl_size(); i++) send_item(1'b0, pick(style));
    for (int i = 0; i < imgs; i++) send_item(1'b1, pick(style));
    push <= 1'b0;
  endtask

  initial begin
    int rnd_items, h, w, th, tw, imgs;
    bit m, reload;
    repeat (5) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // image samples before any template are dropped
    for (int i = 0; i < 3; i++) send_item(1'b1, pick(0));
    push <= 1'b0;
    run_phase(0, 3, 4, 2, 2, 12, 1, 1);
    run_phase(1, 3, 4, 2, 2, 14, 1, 0);
    run_phase(1, 3, 3, 2, 2, 9, 1, 2);
    run_phase(0, 3, 3, 2, 2, 0, 1, 0);
    run_phase(0, 3, 3, 2, 2, 9, 1, 0);
    run_phase(0, 0, 4, 1, 0, 6, 1, 0);
    run_phase(0, 5, 3, 2, 2, 8, 1, 0);
    run_phase(0, 3, 3, 2, 2, 9, 0, 0);
    steady = 1'b1;
    run_phase(0, 2047, 1, 2, 1, 20, 1, 0);
    run_phase(0, 2, 2000, 2, 1, 20, 1, 1);
    steady = 1'b0;
    run_phase(1, 32, 2, 63, 1, 64, 1, 0);

    rnd_items = 0;
    h = 4; w = 4; th = 2; tw = 2;
    while (rnd_items < 60) begin
      m = $urandom_range(0, 1);
      reload = ($urandom_range(0, 5) != 0);
      if (reload) begin
        th = $urandom_range(2, 5);
        tw = $urandom_range(1, 5);
        h = $urandom_range(1, 9);
        w = $urandom_range(1, 9);
      end
      imgs = h * w + $urandom_range(0, h * w / 2);
      if ($urandom_range(0, 7) == 0) imgs = $urandom_range(1, h * w);
      if (rnd_items == 0) begin
        settle();
        hold_rx = 1'b1;
        imgs = 40;
        h = 6; w = 10; th = 2; tw = 2; reload = 1'b1;
      end
      steady = ($urandom_range(0, 4) == 0);
      run_phase(m, h, w, th, tw, imgs, reload, $urandom_range(0, 3));
      rnd_items += imgs + (reload ? th * tw : 0);
    end
    steady = 1'b0;

    while (sb.want.size() != 0) @(posedge clk_i);
    repeat (1300) @(posedge clk_i);
    if (sb.errors == 0)
      $display("Regression PASS");
    else
      $display("Regression FAIL");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/tmssd_pkg.sv
rtl/tmssd_ram.sv
rtl/tmssd_front.sv
rtl/tmssd_jobq.sv
rtl/tmssd_back.sv
rtl/template_match_ssd_nssd.sv
verif/template_match_ssd_nssd_tb.sv
